// ----- src/timestamped_history_lookup_unit_assert.svh -----
// Assertion macros used by the history lookup RTL.
// They sample on clk and are disabled while arst_n is low.
`ifndef TIMESTAMPED_HISTORY_LOOKUP_UNIT_ASSERT_SVH
`define TIMESTAMPED_HISTORY_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define THL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define THL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/thl_pkg.sv -----
`default_nettype none

package thl_pkg;

	// Width and reset value of the capacity register.
	localparam int unsigned CAP_BITS = 10;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 10'd512;

	// Request opcodes carried in the slave tuser.
	localparam int unsigned OPC_BITS = 2;
	localparam logic [OPC_BITS-1:0] OP_PUSH   = 2'd0;
	localparam logic [OPC_BITS-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OPC_BITS-1:0] OP_CLEAR  = 2'd2;

endpackage

`default_nettype wire

// ----- src/thl_ram.sv -----
`default_nettype none

// Simple dual-port record memory: one write port, one read port with
// registered read data. Entries hold no reset value.
module thl_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned WIDTH = 240
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/timestamped_history_lookup_unit.sv -----
// Timestamped history lookup unit. The block keeps the most recent records
// of time-stamped position and velocity (Q16.16 coordinates, microsecond
// stamps) in a ring held in one synchronous record memory. A push request
// writes the next ring slot; a clear request empties the history; opcode
// three is dropped. A lookup request reads the ring from the oldest record
// toward the newest, one record per cycle through the single read port of
// the memory, and stops at the first record stamped later than the query.
// It answers with the last record at or before the query, the oldest
// record when every stamp is later, or found low with zero data when the
// history is empty. A lookup passes through the scan state and then the wait
// state; an empty lookup goes straight to the wait state. The block takes one
// request at a time, but a finished answer sits in an output register, so the
// next request is taken while the answer waits for the sink. The user must
// write the capacity register only while the block is idle; the block does not
// enforce this. Lowering it drops the surplus oldest records at the next push.
`default_nettype none

`include "timestamped_history_lookup_unit_assert.svh"

module timestamped_history_lookup_unit
	import thl_pkg::*;
#(
	parameter int unsigned DEPTH      = 512,
	parameter int unsigned TIME_BITS  = 48,
	parameter int unsigned COORD_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Request stream.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// From bit 0 up: timestamp, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero fill.
	input  wire logic [((TIME_BITS+6*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// opcode.
	input  wire logic [OPC_BITS-1:0]   s_tuser,
	// Answer stream.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// From bit 0 up: hit_pos_x, hit_pos_y, hit_pos_z, hit_vel_x, hit_vel_y,
	// hit_vel_z, zero fill.
	output logic [((6*COORD_BITS+7)/8)*8-1:0] m_tdata,
	// found.
	output logic [0:0]                 m_tuser,
	// Capacity register write channel.
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CAP_BITS-1:0]   cfg_data
);

	localparam int unsigned SLOT_W  = $clog2(DEPTH);
	localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
	localparam int unsigned REC_W   = TIME_BITS + 6 * COORD_BITS;
	localparam int unsigned OUT_W   = 6 * COORD_BITS;
	localparam int unsigned OUT_PAD = ((OUT_W + 7) / 8) * 8;
	localparam int unsigned CMP_W   = ((CNT_W + 1) > CAP_BITS) ? (CNT_W + 1) : CAP_BITS;
	localparam int unsigned O_W     = SLOT_W + 2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]           state_q;
	logic [CAP_BITS-1:0]  cap_q;
	logic [SLOT_W-1:0]    newest_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [TIME_BITS-1:0] ts_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     iss_q;
	logic [SLOT_W-1:0]    rd_addr_q;
	logic                 rd_vld_s1;
	logic [CNT_W-1:0]     idx_s1;
	logic                 found_q;
	logic [OUT_W-1:0]     best_q;

	logic                 m_tvalid_q;
	logic                 out_found_q;
	logic [OUT_W-1:0]     out_data_q;

	logic                 accept;
	logic [OPC_BITS-1:0]  in_op;
	logic [TIME_BITS-1:0] in_ts;
	logic [SLOT_W-1:0]    slot_nxt;
	logic [SLOT_W-1:0]    addr_nxt;
	logic [CMP_W-1:0]     cap_ext;
	logic [CMP_W-1:0]     eff_cap;
	logic [CMP_W-1:0]     cnt_inc;
	logic [CNT_W-1:0]     cnt_push;
	logic [O_W-1:0]       osum;
	logic [O_W-1:0]       owrap;
	logic [SLOT_W-1:0]    oldest;
	logic                 issue;
	logic                 ram_we;
	logic [REC_W-1:0]     rd_data;
	logic [TIME_BITS-1:0] rd_time;
	logic [OUT_W-1:0]     rd_payload;
	logic                 hit;
	logic                 stop;
	logic                 out_free;

	// Request decode. Only an idle block takes a request.
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign in_op    = s_tuser;
	assign in_ts    = s_tdata[TIME_BITS-1:0];

	// Ring slot arithmetic; DEPTH need not be a power of two.
	assign slot_nxt = (newest_q == SLOT_W'(DEPTH - 1)) ? '0 : newest_q + 1'b1;
	assign addr_nxt = (rd_addr_q == SLOT_W'(DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;

	// The oldest record sits count - 1 slots behind the newest. With a non-empty
	// history the sum stays below twice the depth; one conditional subtract wraps it.
	assign osum   = O_W'(newest_q) + O_W'(DEPTH + 1) - O_W'(cnt_q);
	assign owrap  = osum - O_W'(DEPTH);
	assign oldest = (osum >= O_W'(DEPTH)) ? owrap[SLOT_W-1:0] : osum[SLOT_W-1:0];

	// A capacity above the depth saturates to the depth. The count after a
	// push is clamped to the capacity, which also trims a lowered capacity.
	assign cap_ext  = CMP_W'(cap_q);
	assign eff_cap  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
	assign cnt_inc  = CMP_W'(cnt_q) + 1'b1;
	assign cnt_push = (cnt_inc > eff_cap) ? eff_cap[CNT_W-1:0] : cnt_inc[CNT_W-1:0];

	// Each record is compared in the cycle after its read. Reads issued after the
	// scan stops return into the wait state and are ignored there.
	assign issue  = (state_q == ST_SCAN) && (iss_q < n_q);
	assign ram_we = accept && (in_op == OP_PUSH);

	thl_ram #(
		.DEPTH (DEPTH),
		.WIDTH (REC_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_nxt),
		.wdata (s_tdata[REC_W-1:0]),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	assign rd_time    = rd_data[TIME_BITS-1:0];
	assign rd_payload = rd_data[REC_W-1:TIME_BITS];
	assign hit        = (rd_time <= ts_q);
	assign stop       = !hit || (idx_s1 == n_q - 1'b1);
	assign out_free   = !m_tvalid_q || m_tready;

	// Capacity register; it is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// History pointers. A clear keeps the newest slot where it is.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			cnt_q    <= '0;
		end else if (accept) begin
			case (in_op)
				OP_PUSH: begin
					newest_q <= slot_nxt;
					cnt_q    <= cnt_push;
				end
				OP_CLEAR: begin
					cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Lookup sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iss_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_op == OP_LOOKUP)) begin
						iss_q   <= '0;
						state_q <= (cnt_q == '0) ? ST_WAIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (rd_vld_s1 && stop) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Lookup datapath. The first record read is kept even when it is later
	// than the query, which gives the oldest record as the fallback answer.
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q;
		if (issue) begin
			rd_addr_q <= addr_nxt;
		end
		if (accept && (in_op == OP_LOOKUP)) begin
			ts_q      <= in_ts;
			n_q       <= cnt_q;
			rd_addr_q <= oldest;
			found_q   <= (cnt_q != '0);
			if (cnt_q == '0) begin
				best_q <= '0;
			end
		end
		if ((state_q == ST_SCAN) && rd_vld_s1 && (hit || (idx_s1 == '0))) begin
			best_q <= rd_payload;
		end
	end

	// Output register: it frees the sink side from the lookup sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_WAIT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WAIT) && out_free) begin
			out_found_q <= found_q;
			out_data_q  <= best_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tuser[0] = out_found_q;
	assign m_tdata    = OUT_PAD'(out_data_q);

	// The record count never exceeds the ring depth.
	`THL_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_q <= CNT_W'(DEPTH)), "record count above depth")
	// A lookup on an empty history goes straight to the wait state with found low.
	`THL_ASSERT_NEXT(a_empty_lookup, (accept && (in_op == OP_LOOKUP) && (cnt_q == '0)),
		((state_q == ST_WAIT) && !found_q), "empty lookup did not answer not-found")
	// A new answer is only loaded from the wait state.
	`THL_ASSERT_NOW(a_out_from_wait, $rose(m_tvalid), ($past(state_q) == ST_WAIT),
		"answer appeared outside the wait state")
	// Every record compared during a scan lies inside the live history.
	`THL_ASSERT_NOW(a_scan_index, ((state_q == ST_SCAN) && rd_vld_s1), (idx_s1 < n_q),
		"scan read past the newest record")

endmodule

`default_nettype wire

// ----- bench/thl_checker.sv -----
`default_nettype none

// Watches the request, answer and capacity channels of the history lookup
// unit, keeps its own copy of the record ring and compares every answer.
module thl_checker
	import thl_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	// From bit 0 up: timestamp, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z.
	input  wire logic [239:0]        s_tdata,
	// opcode.
	input  wire logic [OPC_BITS-1:0] s_tuser,
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	// From bit 0 up: hit_pos_x, hit_pos_y, hit_pos_z, hit_vel_x, hit_vel_y, hit_vel_z.
	input  wire logic [191:0]        m_tdata,
	// found.
	input  wire logic [0:0]          m_tuser,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [CAP_BITS-1:0] cfg_data,
	output int                       mismatches,
	output int                       answers_due
);

	localparam int SLOTS     = 512;
	// The block holds at most two answers at once, so a few entries suffice.
	localparam int DUE_SLOTS = 16;

	typedef struct packed {
		logic             found;
		logic [5:0][31:0] coord;
	} answer_t;

	string field_names [6] = '{"hit_pos_x", "hit_pos_y", "hit_pos_z",
		"hit_vel_x", "hit_vel_y", "hit_vel_z"};

	logic [47:0]       ring_stamp [SLOTS];
	logic [5:0][31:0]  ring_coord [SLOTS];
	logic [8:0]        head;
	int                ring_count;
	logic [CAP_BITS-1:0] cap_reg;
	answer_t           due_answers [DUE_SLOTS];
	int                due_wr;
	int                due_rd;

	always @(posedge clk or negedge arst_n) begin
		answer_t    want;
		logic [8:0] slot;
		logic [8:0] best;
		int         keep;
		if (!arst_n) begin
			head = '0;
			ring_count = 0;
			cap_reg = CAP_RESET;
			due_wr = 0;
			due_rd = 0;
			mismatches = 0;
			answers_due = 0;
		end else begin
			// An answer can never leave in the cycle its lookup is taken, so
			// answers are matched before this cycle's request is applied.
			if (m_tvalid && m_tready) begin
				if (due_wr == due_rd) begin
					$display("%0t: answer with nothing expected, found %0b data %h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = due_answers[due_rd % DUE_SLOTS];
					due_rd++;
					if (m_tuser[0] !== want.found) begin
						$display("%0t: found expected %0b got %0b", $time, want.found, m_tuser[0]);
						mismatches++;
					end
					for (int k = 0; k < 6; k++) begin
						if (m_tdata[32*k +: 32] !== want.coord[k]) begin
							$display("%0t: %s expected %h got %h", $time, field_names[k],
								want.coord[k], m_tdata[32*k +: 32]);
							mismatches++;
						end
					end
				end
			end
			if (cfg_valid && cfg_ready)
				cap_reg = cfg_data;
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					OP_PUSH: begin
						head = head + 9'd1;
						ring_stamp[head] = s_tdata[47:0];
						ring_coord[head] = s_tdata[239:48];
						keep = (int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg);
						ring_count = (ring_count + 1 > keep) ? keep : ring_count + 1;
					end
					OP_LOOKUP: begin
						want = '0;
						if (ring_count != 0) begin
							slot = head - 9'(ring_count - 1);
							best = slot;
							for (int i = 0; i < ring_count; i++) begin
								if (ring_stamp[slot] > s_tdata[47:0])
									break;
								best = slot;
								slot = slot + 9'd1;
							end
							want.found = 1'b1;
							want.coord = ring_coord[best];
						end
						due_answers[due_wr % DUE_SLOTS] = want;
						due_wr++;
					end
					OP_CLEAR: ring_count = 0;
					default: ;
				endcase
			end
			answers_due = due_wr - due_rd;
		end
	end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

// Top of the bench for the history lookup unit. It makes the requests,
// the capacity writes and the answer-side backpressure, and gives the
// verdict from the mismatch and pending-answer counts that the checker hands back.
module tb_top
	import thl_pkg::*;
();

	// The fourth opcode has no meaning and must be dropped by the block.
	localparam logic [OPC_BITS-1:0] OP_UNUSED = 2'd3;

	// Cycles without any accepted transfer before the run is declared hung.
	// The longest quiet stretch of a correct run is one full-ring lookup
	// plus random stalls.
	localparam int STALL_LIMIT   = 20000;
	// Quiet cycles before a capacity write.
	localparam int SETTLE_CYCLES = 16;
	// Quiet cycles at the end, longer than a full-ring lookup.
	localparam int DRAIN_CYCLES  = 600;
	// Number of recent push stamps kept for aiming queries.
	localparam int RECENT_SLOTS  = 8;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// From bit 0 up: timestamp, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z.
	logic [239:0]        s_tdata;
	// opcode.
	logic [OPC_BITS-1:0] s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// From bit 0 up: hit_pos_x, hit_pos_y, hit_pos_z, hit_vel_x, hit_vel_y, hit_vel_z.
	logic [191:0]        m_tdata;
	// found.
	logic [0:0]          m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_BITS-1:0] cfg_data;

	int                  send_idle;
	int                  recv_idle;
	int                  mismatches;
	int                  answers_due;
	int                  stall_cycles;

	// Running stamp for pushes, and the last few pushed stamps, so that most
	// queries land on, next to or between stored records.
	logic [47:0]         stamp_now;
	logic [47:0]         recent_stamps [RECENT_SLOTS];
	int                  recent_count;
	int                  recent_next;

	timestamped_history_lookup_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	thl_checker history_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.answers_due (answers_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The answer side stalls at random; the rate is changed by the stimulus
	// as the run moves from one idling pattern to the next.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Hang detection: any accepted request, answer or capacity write resets
	// the count of quiet cycles.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Packs a position and a velocity given as one value per triple, with
	// pos_x in the lowest word.
	function automatic logic [5:0][31:0] record_coords(input logic [31:0] pos,
		input logic [31:0] vel);
		return {{3{vel}}, {3{pos}}};
	endfunction

	// Offers one request from a falling edge and returns at the falling edge
	// after it was taken, with tvalid still high. The next call either keeps
	// it high with new data or lowers it for a gap, so tvalid is assigned
	// only once per time step.
	task automatic send_request(input logic [OPC_BITS-1:0] op, input logic [47:0] stamp,
		input logic [5:0][31:0] coords);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {coords, stamp};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Stops offering requests and waits until every answer is back, then
	// lets the block finish any push or clear still in flight.
	task automatic settle(input int cycles);
		s_tvalid <= 1'b0;
		while (answers_due != 0) @(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	// Capacity is written only once the block is idle.
	task automatic write_capacity(input logic [CAP_BITS-1:0] value);
		settle(SETTLE_CYCLES);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random request. Pushes mostly carry rising stamps, with repeats
	// and a share of stamps anywhere in range, so the scan sees ordered
	// histories as well as disordered ones. Queries are mostly near a recent
	// stamp, some exactly on it, some at the extremes and some anywhere.
	task automatic random_request(input int push_pct, input int lookup_pct, input int clear_pct);
		int                  pick;
		logic [63:0]         wide;
		logic [47:0]         stamp;
		logic [5:0][31:0]    coords;
		logic [OPC_BITS-1:0] op;
		pick = $urandom_range(99);
		wide = {$urandom, $urandom};
		stamp = wide[47:0];
		for (int k = 0; k < 6; k++)
			coords[k] = $urandom;
		if (pick < push_pct) begin
			op = OP_PUSH;
			if ($urandom_range(9) != 0) begin
				stamp_now = stamp_now + 48'($urandom_range(1000));
				stamp = stamp_now;
			end
			recent_stamps[recent_next] = stamp;
			recent_next = (recent_next + 1) % RECENT_SLOTS;
			if (recent_count < RECENT_SLOTS)
				recent_count++;
		end else if (pick < push_pct + lookup_pct) begin
			op = OP_LOOKUP;
			case ($urandom_range(9))
				0: stamp = '0;
				1: stamp = '1;
				2, 3: ;
				4: begin
					if (recent_count != 0)
						stamp = recent_stamps[$urandom_range(recent_count - 1)];
				end
				default: begin
					if (recent_count != 0)
						stamp = recent_stamps[$urandom_range(recent_count - 1)]
							+ 48'($urandom_range(600)) - 48'd300;
				end
			endcase
		end else if (pick < push_pct + lookup_pct + clear_pct) begin
			op = OP_CLEAR;
		end else begin
			op = OP_UNUSED;
		end
		send_request(op, stamp, coords);
	endtask

	// A phase sets the capacity and then runs a random mix of requests.
	task automatic run_phase(input logic [CAP_BITS-1:0] capacity, input int items,
		input int push_pct, input int lookup_pct, input int clear_pct);
		write_capacity(capacity);
		stamp_now = {16'($urandom_range(32'h7FFF)), $urandom};
		recent_count = 0;
		recent_next = 0;
		repeat (items) random_request(push_pct, lookup_pct, clear_pct);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_PUSH;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle = 28;
		recv_idle = 81;
		stamp_now = '0;
		recent_count = 0;
		recent_next = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, at the reset capacity. Lookups on an empty history
		// must answer not-found with zero data, and the fourth opcode must
		// produce nothing.
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_LOOKUP, '1, '1);
		send_request(OP_UNUSED, '1, '1);
		// Extreme coordinates, a repeated stamp, a stamp out of order and the
		// largest stamp.
		send_request(OP_PUSH, 48'd100, record_coords(32'h7FFF_FFFF, 32'h8000_0000));
		send_request(OP_PUSH, 48'd200, record_coords(32'h8000_0000, 32'h7FFF_FFFF));
		send_request(OP_PUSH, 48'd200, record_coords(32'hA5A5_A5A5, 32'h5A5A_5A5A));
		send_request(OP_PUSH, 48'd150, record_coords(32'h0000_0000, 32'hFFFF_FFFF));
		send_request(OP_PUSH, '1, record_coords(32'h0000_0001, 32'h0001_0000));
		// Queries below the oldest stamp fall back to the oldest record; the
		// others stop at the first later stamp, which with the disordered
		// stamp above lands past the repeated ones.
		send_request(OP_LOOKUP, 48'd0, '0);
		send_request(OP_LOOKUP, 48'd99, '0);
		send_request(OP_LOOKUP, 48'd100, '0);
		send_request(OP_LOOKUP, 48'd199, '0);
		send_request(OP_LOOKUP, 48'd200, '0);
		send_request(OP_LOOKUP, '1, '0);
		send_request(OP_LOOKUP, 48'hFFFF_FFFF_FFFE, '0);
		// After a clear the history is empty again.
		send_request(OP_CLEAR, 48'd500, '1);
		send_request(OP_LOOKUP, 48'd500, '0);
		send_request(OP_PUSH, '0, '0);
		send_request(OP_LOOKUP, '0, '1);
		send_request(OP_UNUSED, 48'd0, '0);
		send_request(OP_LOOKUP, '1, '0);
		send_request(OP_CLEAR, '0, '0);

		// Small capacities first, including zero, where pushes store nothing.
		run_phase(10'd1, 60, 50, 40, 5);
		run_phase(10'd0, 40, 50, 45, 3);
		run_phase(10'd5, 120, 55, 35, 6);

		// A capacity above the ring size saturates; this phase is mostly
		// pushes so that the ring wraps.
		send_idle = 81;
		recv_idle = 28;
		run_phase(10'd1023, 560, 88, 10, 0);
		// Lowering the capacity keeps the surplus records visible to lookups
		// until the next push drops them.
		write_capacity(10'd3);
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_LOOKUP, '1, '0);
		send_request(OP_LOOKUP, stamp_now, '0);
		send_request(OP_LOOKUP, stamp_now - 48'd2000, '0);
		repeat (46) random_request(55, 40, 3);

		// No idling on either side from here on.
		send_idle = 0;
		recv_idle = 0;
		run_phase(10'd512, 100, 60, 35, 3);
		run_phase(10'($urandom_range(40, 2)), 120, 55, 38, 4);

		settle(DRAIN_CYCLES);
		if (mismatches == 0 && answers_due == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/thl_pkg.sv
src/thl_ram.sv
src/timestamped_history_lookup_unit.sv
bench/thl_checker.sv
bench/tb_top.sv
